// ===== rtl/mx_pkg.sv =====
// Shared types and constants for the modular exponentiation block.
package mx_pkg;

  // Width of the operand and result payload fields on the channels.
  localparam int FIELD_W = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_MULT,
    ST_UPDATE,
    ST_FINISH
  } mx_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic load;
    logic mul_init;
    logic step;
    logic mul_done;
    logic out_load;
  } mx_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_valid;
    logic mod_zero;
    logic exp_zero;
    logic out_full;
  } mx_sts_t;

endpackage

// ===== rtl/mx_if.sv =====
// Valid/ready channel interfaces for operands and results.
interface mx_in_if;
  logic                        valid;
  logic                        ready;
  logic [mx_pkg::FIELD_W-1:0]  base_value;
  logic [mx_pkg::FIELD_W-1:0]  exponent;
  logic [mx_pkg::FIELD_W-1:0]  modulus;

  modport source (output valid, output base_value, output exponent, output modulus,
                  input ready);
  modport sink   (input valid, input base_value, input exponent, input modulus,
                  output ready);
endinterface

interface mx_out_if;
  logic                        valid;
  logic                        ready;
  logic [mx_pkg::FIELD_W-1:0]  power_result;
  logic                        zero_modulus_error;

  modport source (output valid, output power_result, output zero_modulus_error,
                  input ready);
  modport sink   (input valid, input power_result, input zero_modulus_error,
                  output ready);
endinterface

// ===== rtl/mx_modmul.sv =====
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle while step is high.
module mx_modmul #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         init,
  input  logic         step,
  input  logic [W-1:0] p_init,
  input  logic [W-1:0] q_init,
  input  logic [W-1:0] m,
  output logic [W-1:0] result
);

  logic [W-1:0] a_r, p_r, q_r;
  logic [W-1:0] a_nxt;
  logic [W+2:0] t, d1, d2;

  // 2a + q*bit stays below 3m; subtract m or 2m to bring it back below m.
  always_comb begin
    t  = {2'b00, a_r, 1'b0} + (p_r[W-1] ? {3'b000, q_r} : '0);
    d1 = t - {3'b000, m};
    d2 = t - {2'b00, m, 1'b0};
    if (!d2[W+2]) begin
      a_nxt = d2[W-1:0];
    end else if (!d1[W+2]) begin
      a_nxt = d1[W-1:0];
    end else begin
      a_nxt = t[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (init) begin
      a_r <= '0;
      p_r <= p_init;
      q_r <= q_init;
    end else if (step) begin
      a_r <= a_nxt;
      p_r <= {p_r[W-2:0], 1'b0};
    end
  end

  assign result = a_r;

endmodule

// ===== rtl/mx_datapath.sv =====
// Operand registers, square and multiply units, and the result register.
module mx_datapath #(
  parameter int W = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  mx_pkg::mx_cmd_t cmd,
  output mx_pkg::mx_sts_t sts,
  mx_in_if.sink           in_ch,
  mx_out_if.source        out_ch
);
  import mx_pkg::*;

  logic [W-1:0] m_r, e_r, acc_r;
  logic [W-1:0] pw, mul_res, acc_sel, sq_p, sq_q;
  logic         out_valid_r, out_err_r;
  logic [FIELD_W-1:0] out_result_r;

  // The square unit first reduces the base (base * 1 mod m), then holds the power.
  assign sq_p    = cmd.load ? in_ch.base_value[W-1:0] : pw;
  assign sq_q    = cmd.load ? W'(1) : pw;
  // Only the initial 1 can reach m (modulus of one); it then reduces to 0.
  assign acc_sel = (acc_r >= m_r) ? '0 : acc_r;

  mx_modmul #(.W(W)) u_sq (
    .clk    (clk),
    .init   (cmd.load | cmd.mul_init),
    .step   (cmd.step),
    .p_init (sq_p),
    .q_init (sq_q),
    .m      (m_r),
    .result (pw)
  );

  mx_modmul #(.W(W)) u_mul (
    .clk    (clk),
    .init   (cmd.mul_init),
    .step   (cmd.step),
    .p_init (acc_sel),
    .q_init (pw),
    .m      (m_r),
    .result (mul_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r   <= '0;
      acc_r <= W'(1);
    end else if (cmd.load) begin
      m_r   <= in_ch.modulus[W-1:0];
      acc_r <= W'(1);
    end else if (cmd.mul_done && e_r[0]) begin
      acc_r <= mul_res;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      e_r <= in_ch.exponent[W-1:0];
    end else if (cmd.mul_done) begin
      e_r <= {1'b0, e_r[W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_err_r    <= (m_r == '0);
      out_result_r <= (m_r == '0) ? '0 : FIELD_W'(acc_r);
    end
  end

  assign in_ch.ready               = cmd.in_ready;
  assign out_ch.valid              = out_valid_r;
  assign out_ch.power_result       = out_result_r;
  assign out_ch.zero_modulus_error = out_err_r;

  assign sts.in_valid = in_ch.valid;
  assign sts.mod_zero = (m_r == '0);
  assign sts.exp_zero = (e_r == '0);
  assign sts.out_full = out_valid_r && !out_ch.ready;

  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (m_r != '0) && (acc_r != W'(1)) |-> acc_r < m_r)
    else $error("accumulator not reduced below modulus");

  a_pw_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_done && (m_r != '0) |-> pw < m_r)
    else $error("power not reduced below modulus");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && !out_ch.ready))
    else $error("pending result overwritten");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_result_r == '0)
    else $error("zero modulus result not zero");

endmodule

// ===== rtl/mx_ctrl.sv =====
// Sequencer for reduction, square-and-multiply rounds and result hand-off.
module mx_ctrl #(
  parameter int W = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  mx_pkg::mx_sts_t sts,
  output mx_pkg::mx_cmd_t cmd
);
  import mx_pkg::*;

  localparam int CW = $clog2(W);

  mx_state_t     state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          cnt_last;

  assign cnt_last = (cnt_r == CW'(W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_last) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.mod_zero || sts.exp_zero) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.mul_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = ST_MULT;
        end
      end
      ST_MULT: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_last) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.mul_done = 1'b1;
        state_nxt    = ST_CHECK;
      end
      ST_FINISH: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_init_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_init |-> !sts.exp_zero && !sts.mod_zero)
    else $error("round started with nothing to do");

  a_reduce_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> ##(W+1) state_r == ST_CHECK)
    else $error("base reduction length wrong");

  a_finish_via_check: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_FINISH) |-> $past(state_r) == ST_CHECK)
    else $error("finish entered out of order");

endmodule

// ===== rtl/modular_exponentiation_64.sv =====
// Top level: modular exponentiation, right-to-left binary square and multiply.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+---------------------------------------------
//  in_ch    | in  | valid / ready | base_value[63:0], exponent[63:0], modulus[63:0]
//  out_ch   | out | valid / ready | power_result[63:0], zero_modulus_error
//
//  W = OPERAND_WIDTH. The base is first reduced, then each exponent bit takes one
//  pass of the bit-serial interleaved reducers, one multiplier bit per cycle;
//  square and multiply run side by side in two such units.
//  Reset (rst_n, synchronous) idles the sequencer and empties the result register.
//  One item is worked at a time; a finished result waits in its register, and
//  the next item is taken meanwhile. A stalled output holds only the final hand-off.
module modular_exponentiation_64 #(
  parameter int OPERAND_WIDTH = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  mx_in_if.sink    in_ch,
  mx_out_if.source out_ch
);
  import mx_pkg::*;

  mx_cmd_t cmd;
  mx_sts_t sts;

  // Sequencer: owns the state and bit counter, issues commands.
  mx_ctrl #(.W(OPERAND_WIDTH)) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Datapath: operand registers, two modular multipliers, result register.
  // Operand bits above OPERAND_WIDTH are dropped at load.
  mx_datapath #(.W(OPERAND_WIDTH)) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sts    (sts),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
